// File: hdl/power_rail_sequencer_macros.svh
// Assertion macros for the sequencer RTL.
`ifndef POWER_RAIL_SEQUENCER_MACROS_SVH
`define POWER_RAIL_SEQUENCER_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define PRS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked at every rising edge out of reset.
`define PRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hdl/prs_pkg.sv
package prs_pkg;

    localparam int RAIL_W   = 16;
    localparam int STATUS_W = 2 * RAIL_W;

    // Sequencer states, one-hot.
    typedef enum logic [10:0] {
        ST_FAIL = 11'b000_0000_0001,
        ST_INIT = 11'b000_0000_0010,
        ST_DOWN = 11'b000_0000_0100,
        ST_OFF  = 11'b000_0000_1000,
        ST_L1   = 11'b000_0001_0000,
        ST_L2   = 11'b000_0010_0000,
        ST_L3   = 11'b000_0100_0000,
        ST_L4   = 11'b000_1000_0000,
        ST_L5   = 11'b001_0000_0000,
        ST_L6   = 11'b010_0000_0000,
        ST_ON   = 11'b100_0000_0000
    } t_seq_state;

    // Encoded state as seen on the result port.
    localparam logic [3:0] CODE_FAIL = 4'd0;
    localparam logic [3:0] CODE_INIT = 4'd1;
    localparam logic [3:0] CODE_DOWN = 4'd2;
    localparam logic [3:0] CODE_OFF  = 4'd3;
    localparam logic [3:0] CODE_L1   = 4'd4;
    localparam logic [3:0] CODE_L2   = 4'd5;
    localparam logic [3:0] CODE_L3   = 4'd6;
    localparam logic [3:0] CODE_L4   = 4'd7;
    localparam logic [3:0] CODE_L5   = 4'd8;
    localparam logic [3:0] CODE_L6   = 4'd9;
    localparam logic [3:0] CODE_ON   = 4'd10;

    typedef enum logic [2:0] {
        CMD_NONE       = 3'd0,
        CMD_POWER_OFF  = 3'd1,
        CMD_TEMP_ALARM = 3'd2,
        CMD_TEMP_CLEAR = 3'd3,
        CMD_POWER_ON   = 3'd4,
        CMD_FAIL_CLEAR = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_ON    = 3'd1,
        EV_OFF   = 3'd2,
        EV_TEMP  = 3'd3,
        EV_FAIL  = 3'd4,
        EV_CLEAR = 3'd5
    } t_event;

    // Per-rail status codes.
    localparam logic [1:0] RS_OFF      = 2'd0;
    localparam logic [1:0] RS_ON       = 2'd1;
    localparam logic [1:0] RS_DISABLED = 2'd2;
    localparam logic [1:0] RS_FAILED   = 2'd3;

    // Enable levels.
    localparam logic [2:0] LVL_NONE = 3'd0;
    localparam logic [2:0] LVL_1    = 3'd1;
    localparam logic [2:0] LVL_2    = 3'd2;
    localparam logic [2:0] LVL_3    = 3'd3;
    localparam logic [2:0] LVL_4    = 3'd4;
    localparam logic [2:0] LVL_5    = 3'd5;
    localparam logic [2:0] LVL_6    = 3'd6;

    // Configuration register indexes.
    localparam logic [2:0] REG_ALL_REQ  = 3'd0;
    localparam logic [2:0] REG_LEVEL1   = 3'd1;
    localparam logic [2:0] REG_LEVEL2   = 3'd2;
    localparam logic [2:0] REG_LEVEL4   = 3'd3;
    localparam logic [2:0] REG_LEVEL5   = 3'd4;
    localparam logic [2:0] REG_LEVEL6   = 3'd5;
    localparam logic [2:0] REG_SIX_MODE = 3'd6;
    localparam logic [2:0] REG_FPGA_EN  = 3'd7;

    typedef struct packed {
        logic [RAIL_W-1:0] all_req;
        logic [RAIL_W-1:0] level1;
        logic [RAIL_W-1:0] level2;
        logic [RAIL_W-1:0] level4;
        logic [RAIL_W-1:0] level5;
        logic [RAIL_W-1:0] level6;
        logic              six_mode;
        logic [1:0]        fpga_en;
    } t_cfg;

    typedef struct packed {
        t_seq_state        seq;
        logic              powerdown;
        logic              over_temp;
        logic              rail_alarm;
        logic [RAIL_W-1:0] fail_mask;
    } t_ctl;

    typedef struct packed {
        logic [3:0]          state_code;
        logic [2:0]          enable_level;
        logic                disable_all;
        logic                power_ok;
        t_event              event_code;
        logic [RAIL_W-1:0]   failed_rails;
        logic [STATUS_W-1:0] rail_status;
    } t_result;

    function automatic logic [3:0] seq_code(input t_seq_state st);
        logic [3:0] code;
        unique case (st)
            ST_FAIL: code = CODE_FAIL;
            ST_INIT: code = CODE_INIT;
            ST_DOWN: code = CODE_DOWN;
            ST_OFF:  code = CODE_OFF;
            ST_L1:   code = CODE_L1;
            ST_L2:   code = CODE_L2;
            ST_L3:   code = CODE_L3;
            ST_L4:   code = CODE_L4;
            ST_L5:   code = CODE_L5;
            ST_L6:   code = CODE_L6;
            ST_ON:   code = CODE_ON;
            default: code = CODE_INIT;
        endcase
        return code;
    endfunction

endpackage

// File: hdl/power_rail_sequencer.sv
// Power rail sequencer with fault shutdown, one tick request per item.
// Input channel (i_in_valid / o_in_ready): command, blade enable and two
// power-good samples. Output channel (o_out_valid / i_out_ready): new state
// code, enable level, disable-all, power-ok pulse, event code, latched fail
// mask and the packed two-bit status of every rail.
// Configuration channel (i_cfg_valid / o_cfg_ready): register index and
// data; it is always ready and should be written only while the block idles.
// A request is captured in an input register and evaluated once the result
// register is free, when the step logic writes the sequencer state and the
// result register together. Throughput is one request per cycle while the
// receiver takes every result; the limit is the single state update per cycle
// that each request needs from the one before.
// When the receiver stalls, the result register holds, the next request
// waits in the input register, and o_in_ready drops once both are full.
// Reset (synchronous, active low) empties both registers, puts the sequencer
// in its init state, clears alarms, the fail mask and rail status, and loads
// the configuration defaults (masks zero, both FPGA groups fitted).
`include "power_rail_sequencer_macros.svh"

module power_rail_sequencer #(
    parameter int NUM_RAILS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_command,
    input  logic        i_blade_enable,
    input  logic [15:0] i_good_bits,
    input  logic [15:0] i_status_good_bits,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_control_state,
    output logic [2:0]  o_enable_level,
    output logic        o_disable_all,
    output logic        o_power_ok_pulse,
    output logic [2:0]  o_event_code,
    output logic [15:0] o_failed_rails,
    output logic [31:0] o_rail_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    prs_pkg::t_cfg    cfg;
    prs_pkg::t_ctl    r_ctl;
    prs_pkg::t_ctl    n_ctl;
    logic [prs_pkg::STATUS_W-1:0] r_status;
    logic [prs_pkg::STATUS_W-1:0] n_status;
    prs_pkg::t_result n_res;
    prs_pkg::t_result r_res;

    logic        r_in_valid;
    logic [2:0]  r_in_command;
    logic        r_in_blade;
    logic [15:0] r_in_good;
    logic [15:0] r_in_sgood;
    logic        r_out_valid;
    logic        advance;
    logic        in_take;

    prs_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    prs_step #(
        .NUM_RAILS (NUM_RAILS)
    ) u_step (
        .i_cfg              (cfg),
        .i_ctl              (r_ctl),
        .i_status           (r_status),
        .i_command          (r_in_command),
        .i_blade_enable     (r_in_blade),
        .i_good_bits        (r_in_good),
        .i_status_good_bits (r_in_sgood),
        .o_ctl              (n_ctl),
        .o_status           (n_status),
        .o_result           (n_res)
    );

    // The held request is evaluated once the result register is free.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_take    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ctl       <= '{seq: prs_pkg::ST_INIT, default: '0};
            r_status    <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_ctl       <= n_ctl;
                r_status    <= n_status;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_command <= i_command;
            r_in_blade   <= i_blade_enable;
            r_in_good    <= i_good_bits;
            r_in_sgood   <= i_status_good_bits;
        end
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_control_state  = r_res.state_code;
    assign o_enable_level   = r_res.enable_level;
    assign o_disable_all    = r_res.disable_all;
    assign o_power_ok_pulse = r_res.power_ok;
    assign o_event_code     = r_res.event_code;
    assign o_failed_rails   = r_res.failed_rails;
    assign o_rail_status    = r_res.rail_status;

    `PRS_ASSERT_IMPL(a_dis_no_enable, i_clk, i_rst_n, o_out_valid && o_disable_all, o_enable_level == prs_pkg::LVL_NONE)
    `PRS_ASSERT_IMPL(a_pok_in_on, i_clk, i_rst_n, o_out_valid && o_power_ok_pulse, o_control_state == prs_pkg::CODE_ON)
    `PRS_ASSERT_IMPL(a_fail_has_mask, i_clk, i_rst_n, o_out_valid && (o_event_code == prs_pkg::EV_FAIL), o_failed_rails != 16'd0)
    `PRS_ASSERT_NEXT(a_advance_gives_result, i_clk, i_rst_n, advance, o_out_valid)

endmodule

// File: hdl/prs_regs.sv
module prs_regs (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    output prs_pkg::t_cfg        o_cfg
);

    prs_pkg::t_cfg r_cfg;
    prs_pkg::t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                prs_pkg::REG_ALL_REQ:  n_cfg.all_req  = i_cfg_data;
                prs_pkg::REG_LEVEL1:   n_cfg.level1   = i_cfg_data;
                prs_pkg::REG_LEVEL2:   n_cfg.level2   = i_cfg_data;
                prs_pkg::REG_LEVEL4:   n_cfg.level4   = i_cfg_data;
                prs_pkg::REG_LEVEL5:   n_cfg.level5   = i_cfg_data;
                prs_pkg::REG_LEVEL6:   n_cfg.level6   = i_cfg_data;
                prs_pkg::REG_SIX_MODE: n_cfg.six_mode = i_cfg_data[0];
                prs_pkg::REG_FPGA_EN:  n_cfg.fpga_en  = i_cfg_data[1:0];
                default:               n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{fpga_en: 2'b11, default: '0};
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// File: hdl/prs_step.sv
module prs_step #(
    parameter int NUM_RAILS = 16
) (
    input  prs_pkg::t_cfg                    i_cfg,
    input  prs_pkg::t_ctl                    i_ctl,
    input  logic [prs_pkg::STATUS_W-1:0]     i_status,
    input  logic [2:0]                       i_command,
    input  logic                             i_blade_enable,
    input  logic [prs_pkg::RAIL_W-1:0]       i_good_bits,
    input  logic [prs_pkg::RAIL_W-1:0]       i_status_good_bits,
    output prs_pkg::t_ctl                    o_ctl,
    output logic [prs_pkg::STATUS_W-1:0]     o_status,
    output prs_pkg::t_result                 o_result
);

    localparam logic [prs_pkg::RAIL_W-1:0] RAIL_MASK =
        prs_pkg::RAIL_W'((33'd1 << NUM_RAILS) - 33'd1);

    logic [prs_pkg::RAIL_W-1:0] good;
    logic [prs_pkg::RAIL_W-1:0] sgood;
    logic [prs_pkg::RAIL_W-1:0] req_all;
    logic [prs_pkg::RAIL_W-1:0] lvl_mask;
    prs_pkg::t_ctl              cmd_ctl;
    prs_pkg::t_ctl              n_ctl;
    logic [2:0]                 en;
    logic                       dis;
    logic                       pok;
    prs_pkg::t_event            ev;
    logic                       lvl_check;

    assign good    = i_good_bits & RAIL_MASK;
    assign sgood   = i_status_good_bits & RAIL_MASK;
    assign req_all = i_cfg.all_req & RAIL_MASK;

    // The command takes effect before the state decision.
    always_comb begin
        cmd_ctl = i_ctl;
        case (prs_pkg::t_cmd'(i_command))
            prs_pkg::CMD_POWER_OFF:  cmd_ctl.powerdown = 1'b1;
            prs_pkg::CMD_TEMP_ALARM: cmd_ctl.over_temp = 1'b1;
            prs_pkg::CMD_TEMP_CLEAR: cmd_ctl.over_temp = 1'b0;
            prs_pkg::CMD_POWER_ON:   cmd_ctl.powerdown = 1'b0;
            prs_pkg::CMD_FAIL_CLEAR: begin
                cmd_ctl.rail_alarm = 1'b0;
                cmd_ctl.fail_mask  = '0;
            end
            default: ;
        endcase
    end

    always_comb begin
        unique case (i_ctl.seq)
            prs_pkg::ST_L1: lvl_mask = i_cfg.level1 & RAIL_MASK;
            prs_pkg::ST_L2: lvl_mask = i_cfg.level2 & RAIL_MASK;
            prs_pkg::ST_L4: lvl_mask = i_cfg.level4 & RAIL_MASK;
            prs_pkg::ST_L5: lvl_mask = i_cfg.level5 & RAIL_MASK;
            prs_pkg::ST_L6: lvl_mask = i_cfg.level6 & RAIL_MASK;
            default:        lvl_mask = '0;
        endcase
    end

    always_comb begin
        n_ctl     = cmd_ctl;
        n_ctl.seq = prs_pkg::ST_INIT;
        en        = prs_pkg::LVL_NONE;
        dis       = 1'b0;
        pok       = 1'b0;
        ev        = prs_pkg::EV_NONE;
        lvl_check = 1'b0;
        unique case (i_ctl.seq) inside
            prs_pkg::ST_INIT: n_ctl.seq = prs_pkg::ST_OFF;
            prs_pkg::ST_ON: begin
                if ((good & req_all) != req_all) begin
                    n_ctl.fail_mask  = ~good & req_all;
                    n_ctl.rail_alarm = 1'b1;
                    dis              = 1'b1;
                    ev               = prs_pkg::EV_FAIL;
                    n_ctl.seq        = prs_pkg::ST_FAIL;
                end else if (cmd_ctl.over_temp) begin
                    dis       = 1'b1;
                    ev        = prs_pkg::EV_TEMP;
                    n_ctl.seq = prs_pkg::ST_FAIL;
                end else if (!i_blade_enable || cmd_ctl.powerdown) begin
                    n_ctl.seq = prs_pkg::ST_DOWN;
                end else begin
                    n_ctl.seq = prs_pkg::ST_ON;
                end
            end
            prs_pkg::ST_DOWN: begin
                dis       = 1'b1;
                ev        = prs_pkg::EV_OFF;
                n_ctl.seq = prs_pkg::ST_OFF;
            end
            prs_pkg::ST_OFF: begin
                if (i_blade_enable && !cmd_ctl.powerdown && !cmd_ctl.over_temp &&
                    !cmd_ctl.rail_alarm) begin
                    en        = prs_pkg::LVL_1;
                    ev        = prs_pkg::EV_ON;
                    n_ctl.seq = prs_pkg::ST_L1;
                end else begin
                    n_ctl.seq = prs_pkg::ST_OFF;
                end
            end
            prs_pkg::ST_L3: begin
                // Level three has no power-good check of its own.
                en        = prs_pkg::LVL_4;
                n_ctl.seq = prs_pkg::ST_L4;
            end
            prs_pkg::ST_L1, prs_pkg::ST_L2, prs_pkg::ST_L4, prs_pkg::ST_L5: lvl_check = 1'b1;
            prs_pkg::ST_L6: begin
                // Sitting in level six outside six-level mode restarts the sequence.
                lvl_check = i_cfg.six_mode;
            end
            prs_pkg::ST_FAIL: begin
                if (!cmd_ctl.rail_alarm && !cmd_ctl.over_temp) begin
                    ev        = prs_pkg::EV_CLEAR;
                    n_ctl.seq = prs_pkg::ST_OFF;
                end else begin
                    n_ctl.seq = prs_pkg::ST_FAIL;
                end
            end
            default: n_ctl.seq = prs_pkg::ST_INIT;
        endcase

        if (lvl_check) begin
            if ((good & lvl_mask) != lvl_mask) begin
                n_ctl.fail_mask  = ~good & lvl_mask;
                n_ctl.rail_alarm = 1'b1;
                dis              = 1'b1;
                ev               = prs_pkg::EV_FAIL;
                n_ctl.seq        = prs_pkg::ST_FAIL;
            end else if (i_ctl.seq == prs_pkg::ST_L6 ||
                         (i_ctl.seq == prs_pkg::ST_L5 && !i_cfg.six_mode)) begin
                pok       = 1'b1;
                n_ctl.seq = prs_pkg::ST_ON;
            end else begin
                unique case (i_ctl.seq)
                    prs_pkg::ST_L1: begin
                        en        = prs_pkg::LVL_2;
                        n_ctl.seq = prs_pkg::ST_L2;
                    end
                    prs_pkg::ST_L2: begin
                        en        = prs_pkg::LVL_3;
                        n_ctl.seq = prs_pkg::ST_L3;
                    end
                    prs_pkg::ST_L4: begin
                        en        = prs_pkg::LVL_5;
                        n_ctl.seq = prs_pkg::ST_L5;
                    end
                    prs_pkg::ST_L5: begin
                        en        = prs_pkg::LVL_6;
                        n_ctl.seq = prs_pkg::ST_L6;
                    end
                    default: n_ctl.seq = prs_pkg::ST_INIT;
                endcase
            end
        end
    end

    // Status uses the old state and the fail mask after this request.
    always_comb begin
        o_status = i_status;
        for (int i = 0; i < prs_pkg::RAIL_W; i++) begin
            if (i >= NUM_RAILS) begin
                o_status[2*i +: 2] = prs_pkg::RS_OFF;
            end else if (sgood[i]) begin
                o_status[2*i +: 2] = prs_pkg::RS_ON;
            end else if (!req_all[i]) begin
                o_status[2*i +: 2] = prs_pkg::RS_DISABLED;
            end else if (i_ctl.seq == prs_pkg::ST_OFF || i_ctl.seq == prs_pkg::ST_INIT) begin
                o_status[2*i +: 2] = prs_pkg::RS_OFF;
            end else if (i_ctl.seq == prs_pkg::ST_ON || i_ctl.seq == prs_pkg::ST_FAIL) begin
                o_status[2*i +: 2] = n_ctl.fail_mask[i] ? prs_pkg::RS_FAILED
                                                        : prs_pkg::RS_OFF;
            end
        end
    end

    assign o_ctl                 = n_ctl;
    assign o_result.state_code   = prs_pkg::seq_code(n_ctl.seq);
    assign o_result.enable_level = en;
    assign o_result.disable_all  = dis;
    assign o_result.power_ok     = pok;
    assign o_result.event_code   = ev;
    assign o_result.failed_rails = n_ctl.fail_mask;
    assign o_result.rail_status  = o_status;

endmodule
